// File: rtl/ray_box_slab_test_top_assert.svh
// Assertion macros for the ray/box slab test block.
// Used by the port checker; no other dependencies.
`ifndef RAY_BOX_SLAB_TEST_TOP_ASSERT_SVH
`define RAY_BOX_SLAB_TEST_TOP_ASSERT_SVH

// same-cycle implication
`define RBST_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define RBST_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/rbst_pkg.sv
// Shared types for the ray/box slab test block.
// No dependencies.
`timescale 1ns / 1ps

package rbst_pkg;

    localparam int RBST_AXES  = 3;
    localparam int RBST_LANES = 2 * RBST_AXES;   // near and far bound per axis

    // per-axis flags: zero direction component and origin within the slab
    typedef struct packed {
        logic [RBST_AXES-1:0] zero;     // direction component is zero
        logic [RBST_AXES-1:0] in_slab;  // origin lies within the slab
    } t_axis_flags;

endpackage

// File: rtl/ray_box_slab_test_top.sv
// Ray versus axis-aligned box, slab method, fixed point, fully pipelined.
// One stage per quotient bit of the six restoring dividers sets the pipeline depth.
// Throughput: one transaction per cycle; all stages stall together on output backpressure.
// Reset (i_rst_n low, synchronous) clears the valid bits only; no other state.
// Depends on rbst_pkg.
`timescale 1ns / 1ps

module ray_box_slab_test_top
    import rbst_pkg::*;
#(
    parameter int FRAC_BITS = 16,
    parameter int WORD_BITS = 32
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_s_axis_tvalid,
    output logic o_s_axis_tready,
    // box_center_x/y/z, half_size_x/y/z, ray_origin_x/y/z, ray_dir_x/y/z, zero fill
    input  logic [((12*WORD_BITS-3+7)/8)*8-1:0] i_s_axis_tdata,
    output logic o_m_axis_tvalid,
    input  logic i_m_axis_tready,
    // t_enter, t_exit, zero fill
    output logic [((2*WORD_BITS+7)/8)*8-1:0] o_m_axis_tdata,
    // hit
    output logic [0:0] o_m_axis_tuser
);

    localparam int W      = WORD_BITS;
    localparam int F      = FRAC_BITS;
    localparam int QW     = W - 1;          // quotient bits below saturation
    localparam int NW     = W + 2;          // slab bound width, signed
    localparam int RW     = 2 * W + F + 2;  // divider remainder width
    localparam int OUT_DW = ((2 * W + 7) / 8) * 8;
    localparam int OFS_C  = 0;
    localparam int OFS_H  = 3 * W;
    localparam int OFS_O  = 6 * W - 3;
    localparam int OFS_D  = 9 * W - 3;

    localparam logic signed [W-1:0] TMAX = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] TMIN = {1'b1, {(W-1){1'b0}}};

    // whole pipeline advances when the output register can take a result
    logic w_en;
    logic r_out_valid;
    assign w_en            = !r_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = w_en;

    // ---------------- stage 1: origin relative to centre ----------------
    logic                r1_v;
    logic signed [W:0]   r1_rel [RBST_AXES];
    logic [W-2:0]        r1_h   [RBST_AXES];
    logic signed [W-1:0] r1_d   [RBST_AXES];

    // ---------------- stage 2: slab bounds, near/far selection ----------
    logic                r2_v;
    logic signed [NW-1:0] r2_num [RBST_LANES];
    logic signed [W-1:0]  r2_d   [RBST_AXES];
    t_axis_flags          r2_fl;
    t_axis_flags          n2_fl;
    logic signed [NW-1:0] n2_num [RBST_LANES];

    // ---------------- stage 3: magnitudes and quotient sign -------------
    logic                r3_v;
    logic [NW-1:0]       r3_n   [RBST_LANES];
    logic [W-1:0]        r3_dm  [RBST_LANES];
    logic                r3_neg [RBST_LANES];
    t_axis_flags         r3_fl;

    // ---------------- divider: index 0 is the saturation check stage ----
    logic                r_dv   [0:QW];
    t_axis_flags         r_dfl  [0:QW];
    logic [RW-1:0]       r_rem  [0:QW][RBST_LANES];
    logic [W-1:0]        r_dm   [0:QW][RBST_LANES];
    logic [QW-1:0]       r_q    [0:QW][RBST_LANES];
    logic                r_neg  [0:QW][RBST_LANES];
    logic                r_sat  [0:QW][RBST_LANES];
    logic [RW-1:0]       w_dsh  [QW][RBST_LANES];
    logic                w_ge   [QW][RBST_LANES];
    logic [RW-1:0]       w_r0   [RBST_LANES];
    logic                w_sat0 [RBST_LANES];

    // ---------------- finalize: signed, saturated slab parameters -------
    logic                r5_v;
    logic signed [W-1:0] r5_t   [RBST_LANES];
    logic [RBST_AXES-1:0] r5_ok;
    logic signed [W-1:0] n5_t   [RBST_LANES];

    // ---------------- combine x with y ----------------------------------
    logic                r6_v;
    logic                r6_hit;
    logic signed [W-1:0] r6_t0;
    logic signed [W-1:0] r6_t1;
    logic signed [W-1:0] r6_tn;
    logic signed [W-1:0] r6_tf;
    logic                r6_ok;

    // ---------------- output register (combine with z) ------------------
    logic                r_out_hit;
    logic signed [W-1:0] r_out_t0;
    logic signed [W-1:0] r_out_t1;

    // stage 1
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (w_en) begin
            r1_v <= i_s_axis_tvalid;
        end
    end

    for (genvar ga = 0; ga < RBST_AXES; ga++) begin : g_s1
        logic [W-1:0] w_c;
        logic [W-1:0] w_o;
        assign w_c = i_s_axis_tdata[OFS_C + ga*W +: W];
        assign w_o = i_s_axis_tdata[OFS_O + ga*W +: W];
        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r1_rel[ga] <= $signed({w_o[W-1], w_o}) - $signed({w_c[W-1], w_c});
                r1_h[ga]   <= i_s_axis_tdata[OFS_H + ga*(W-1) +: (W-1)];
                r1_d[ga]   <= $signed(i_s_axis_tdata[OFS_D + ga*W +: W]);
            end
        end
    end

    // stage 2: lo = -h - rel, hi = h - rel; direction sign picks near face
    for (genvar ga = 0; ga < RBST_AXES; ga++) begin : g_s2
        logic signed [NW-1:0] w_h;
        logic signed [NW-1:0] w_rel;
        logic signed [NW-1:0] w_lo;
        logic signed [NW-1:0] w_hi;
        assign w_h   = $signed({3'b000, r1_h[ga]});
        assign w_rel = $signed({r1_rel[ga][W], r1_rel[ga]});
        assign w_lo  = -w_h - w_rel;
        assign w_hi  = w_h - w_rel;
        assign n2_num[2*ga]     = r1_d[ga][W-1] ? w_hi : w_lo;
        assign n2_num[2*ga + 1] = r1_d[ga][W-1] ? w_lo : w_hi;
        assign n2_fl.zero[ga]    = (r1_d[ga] == '0);
        assign n2_fl.in_slab[ga] = (w_lo[NW-1] || (w_lo == '0)) && !w_hi[NW-1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else if (w_en) begin
            r2_v <= r1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r2_num <= n2_num;
            r2_d   <= r1_d;
            r2_fl  <= n2_fl;
        end
    end

    // stage 3: absolute values
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else if (w_en) begin
            r3_v <= r2_v;
        end
    end

    for (genvar gl = 0; gl < RBST_LANES; gl++) begin : g_s3
        localparam int AX = gl / 2;
        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r3_n[gl]   <= r2_num[gl][NW-1] ? NW'(-r2_num[gl]) : NW'(r2_num[gl]);
                r3_dm[gl]  <= r2_d[AX][W-1] ? W'(-r2_d[AX]) : W'(r2_d[AX]);
                r3_neg[gl] <= r2_num[gl][NW-1] ^ r2_d[AX][W-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r3_fl <= r2_fl;
        end
    end

    // divider entry: scale numerator, flag quotients of 2^(W-1) or more
    for (genvar gl = 0; gl < RBST_LANES; gl++) begin : g_s4
        assign w_r0[gl]   = RW'(r3_n[gl]) << F;
        assign w_sat0[gl] = w_r0[gl] >= (RW'(r3_dm[gl]) << QW);
    end

    // one quotient bit per stage, most significant first
    always_comb begin
        for (int k = 0; k < QW; k++) begin
            for (int l = 0; l < RBST_LANES; l++) begin
                w_dsh[k][l] = RW'(r_dm[k][l]) << (QW - 1 - k);
                w_ge[k][l]  = r_rem[k][l] >= w_dsh[k][l];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= QW; k++) begin
                r_dv[k] <= 1'b0;
            end
        end else if (w_en) begin
            r_dv[0] <= r3_v;
            for (int k = 0; k < QW; k++) begin
                r_dv[k+1] <= r_dv[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dfl[0] <= r3_fl;
            for (int l = 0; l < RBST_LANES; l++) begin
                r_rem[0][l] <= w_r0[l];
                r_dm[0][l]  <= r3_dm[l];
                r_q[0][l]   <= '0;
                r_neg[0][l] <= r3_neg[l];
                r_sat[0][l] <= w_sat0[l];
            end
            for (int k = 0; k < QW; k++) begin
                r_dfl[k+1] <= r_dfl[k];
                for (int l = 0; l < RBST_LANES; l++) begin
                    r_rem[k+1][l] <= w_ge[k][l] ? (r_rem[k][l] - w_dsh[k][l]) : r_rem[k][l];
                    r_dm[k+1][l]  <= r_dm[k][l];
                    r_q[k+1][l]   <= r_q[k][l] | (QW'(w_ge[k][l]) << (QW - 1 - k));
                    r_neg[k+1][l] <= r_neg[k][l];
                    r_sat[k+1][l] <= r_sat[k][l];
                end
            end
        end
    end

    // finalize: apply sign and saturation; zero direction spans the full range
    for (genvar gl = 0; gl < RBST_LANES; gl++) begin : g_s5
        localparam int AX = gl / 2;
        logic signed [W-1:0] w_mag;
        assign w_mag = $signed({1'b0, r_q[QW][gl]});
        always_comb begin
            if (r_dfl[QW].zero[AX]) begin
                n5_t[gl] = (gl % 2 == 0) ? TMIN : TMAX;
            end else if (r_sat[QW][gl]) begin
                n5_t[gl] = r_neg[QW][gl] ? TMIN : TMAX;
            end else begin
                n5_t[gl] = r_neg[QW][gl] ? -w_mag : w_mag;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_v <= 1'b0;
        end else if (w_en) begin
            r5_v <= r_dv[QW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r5_t  <= n5_t;
            r5_ok <= ~r_dfl[QW].zero | r_dfl[QW].in_slab;
        end
    end

    // combine x and y intervals; touching intervals still overlap
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_v <= 1'b0;
        end else if (w_en) begin
            r6_v <= r5_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r6_hit <= r5_ok[0] && r5_ok[1] && !(r5_t[0] > r5_t[3]) && !(r5_t[2] > r5_t[1]);
            r6_t0  <= (r5_t[2] > r5_t[0]) ? r5_t[2] : r5_t[0];
            r6_t1  <= (r5_t[3] < r5_t[1]) ? r5_t[3] : r5_t[1];
            r6_tn  <= r5_t[4];
            r6_tf  <= r5_t[5];
            r6_ok  <= r5_ok[2];
        end
    end

    // combine with z into the output register; a miss reports zero parameters
    logic w_hit;
    assign w_hit = r6_hit && r6_ok && !(r6_t0 > r6_tf) && !(r6_tn > r6_t1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= r6_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_hit <= w_hit;
            r_out_t0  <= !w_hit ? '0 : ((r6_tn > r6_t0) ? r6_tn : r6_t0);
            r_out_t1  <= !w_hit ? '0 : ((r6_tf < r6_t1) ? r6_tf : r6_t1);
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_out_hit;
    assign o_m_axis_tdata  = OUT_DW'({r_out_t1, r_out_t0});

endmodule

// File: rtl/rbst_check.sv
// Port-level checker for the ray/box slab test block, bound to the top level.
// Depends on ray_box_slab_test_top_assert.svh.
`timescale 1ns / 1ps
`include "ray_box_slab_test_top_assert.svh"

module rbst_check #(
    parameter int WORD_BITS = 32
) (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_s_axis_tvalid,
    input logic o_s_axis_tready,
    input logic [((12*WORD_BITS-3+7)/8)*8-1:0] i_s_axis_tdata,
    input logic o_m_axis_tvalid,
    input logic i_m_axis_tready,
    input logic [((2*WORD_BITS+7)/8)*8-1:0] o_m_axis_tdata,
    input logic [0:0] o_m_axis_tuser
);

    localparam int W = WORD_BITS;

    logic signed [W-1:0] w_enter;
    logic signed [W-1:0] w_exit;
    assign w_enter = $signed(o_m_axis_tdata[W-1:0]);
    assign w_exit  = $signed(o_m_axis_tdata[2*W-1:W]);

    `RBST_ASSERT_NXT(a_out_hold, o_m_axis_tvalid && !i_m_axis_tready,
        o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser),
        "result changed while stalled")
    `RBST_ASSERT_NOW(a_ready_link, 1'b1,
        o_s_axis_tready == (!o_m_axis_tvalid || i_m_axis_tready),
        "input ready does not follow output backpressure")
    `RBST_ASSERT_NOW(a_miss_zero, o_m_axis_tvalid && !o_m_axis_tuser[0],
        w_enter == '0 && w_exit == '0, "miss with nonzero parameters")
    `RBST_ASSERT_NOW(a_hit_order, o_m_axis_tvalid && o_m_axis_tuser[0],
        w_enter <= w_exit, "hit with entry after exit")

endmodule

bind ray_box_slab_test_top rbst_check #(.WORD_BITS(WORD_BITS)) u_rbst_check (.*);
